FILE: rtl/sgfb_pkg.sv
`default_nettype none

package sgfb_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 16;
  localparam int TAP_W     = 6;
  localparam int BANK_W    = 2;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int GPROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int GAIN_FRAC = 12;
  localparam int COEF_FRAC = 23;
  localparam int NUM_BANKS = 3;
  localparam int NUM_SIDES = 2;
  localparam int NUM_LANES = NUM_SIDES * NUM_BANKS;

  localparam logic [SAMPLE_W-1:0] SAT_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN = 24'h800000;

  // Request codes.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  // Coefficient banks.
  localparam int BANK_LP = 0;
  localparam int BANK_HP = 1;
  localparam int BANK_BP = 2;

  // Sides.
  localparam int SIDE_LEFT  = 0;
  localparam int SIDE_RIGHT = 1;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PRE_GAIN    = 1'b0;
  localparam logic REG_OUTPUT_MODE = 1'b1;
  localparam logic [GAIN_W-1:0] PRE_GAIN_RESET = 16'd4096;
  localparam logic OUTPUT_MODE_RESET = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [BANK_W-1:0]          coef_bank;
    logic [TAP_W-1:0]           coef_tap;
    logic signed [SAMPLE_W-1:0] coef_value;
  } in_word_t;

  typedef struct packed {
    logic                       first_channel;
    logic signed [SAMPLE_W-1:0] direct_left;
    logic signed [SAMPLE_W-1:0] lowpass_left;
    logic signed [SAMPLE_W-1:0] highpass_left;
    logic signed [SAMPLE_W-1:0] bandpass_left;
    logic signed [SAMPLE_W-1:0] bandpass_right;
    logic signed [SAMPLE_W-1:0] highpass_right;
    logic signed [SAMPLE_W-1:0] lowpass_right;
  } out_word_t;

  // Control of one multiply-accumulate lane.
  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GAIN,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Floor shift by the gain fraction and saturation to 24 bits.
  function automatic logic [SAMPLE_W-1:0] gain_sat(input logic signed [GPROD_W-1:0] p);
    logic [GPROD_W-SAMPLE_W-GAIN_FRAC:0] hi;
    hi = p[GPROD_W-1:SAMPLE_W+GAIN_FRAC-1];
    if (hi == '0 || hi == '1) begin
      return p[SAMPLE_W+GAIN_FRAC-1:GAIN_FRAC];
    end
    return p[GPROD_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sgfb_chan_if.sv
`default_nettype none

interface sgfb_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/sgfb_ram.sv
`default_nettype none

module sgfb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sgfb_gain.sv
`default_nettype none

module sgfb_gain
  import sgfb_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [SAMPLE_W-1:0] left_in,
  input  wire logic signed [SAMPLE_W-1:0] right_in,
  input  wire logic [GAIN_W-1:0]          gain,
  output logic      [SAMPLE_W-1:0]        left_out,
  output logic      [SAMPLE_W-1:0]        right_out
);

  logic signed [GPROD_W-1:0] prod_l_r;
  logic signed [GPROD_W-1:0] prod_rt_r;
  logic signed [GAIN_W:0]    gain_s;

  // The gain is unsigned, so it gets a zero sign bit.
  assign gain_s = $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_l_r  <= left_in * gain_s;
      prod_rt_r <= right_in * gain_s;
    end
  end

  assign left_out  = gain_sat(prod_l_r);
  assign right_out = gain_sat(prod_rt_r);

endmodule

`default_nettype wire

FILE: rtl/sgfb_mac_lane.sv
`default_nettype none

module sgfb_mac_lane
  import sgfb_pkg::*;
#(
  parameter int ACC_W = 54
) (
  input  wire logic                clk,
  input  wire lane_ctrl_t          ctrl,
  input  wire logic [SAMPLE_W-1:0] coef,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic      [ACC_W-1:0]    acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= $signed(coef) * $signed(sample);
    end
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.acc) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

FILE: rtl/sgfb_merge.sv
`default_nettype none

module sgfb_merge
  import sgfb_pkg::*;
#(
  parameter int ACC_W = 54
) (
  input  wire logic                clk,
  input  wire logic                load,
  input  wire logic                first_channel,
  input  wire logic [SAMPLE_W-1:0] direct_left,
  input  wire logic [ACC_W-1:0]    acc [NUM_LANES],
  output out_word_t                word
);

  out_word_t word_r;
  logic [SAMPLE_W-1:0] sat [NUM_LANES];

  // Floor shift by the coefficient fraction, then saturate to 24 bits.
  function automatic logic [SAMPLE_W-1:0] acc_sat(input logic [ACC_W-1:0] a);
    logic [ACC_W-SAMPLE_W-COEF_FRAC:0] hi;
    hi = a[ACC_W-1:SAMPLE_W+COEF_FRAC-1];
    if (hi == '0 || hi == '1) begin
      return a[SAMPLE_W+COEF_FRAC-1:COEF_FRAC];
    end
    return a[ACC_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      sat[i] = acc_sat(acc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r.first_channel  <= first_channel;
      word_r.direct_left    <= direct_left;
      word_r.lowpass_left   <= sat[SIDE_LEFT*NUM_BANKS + BANK_LP];
      word_r.highpass_left  <= sat[SIDE_LEFT*NUM_BANKS + BANK_HP];
      word_r.bandpass_left  <= sat[SIDE_LEFT*NUM_BANKS + BANK_BP];
      word_r.bandpass_right <= sat[SIDE_RIGHT*NUM_BANKS + BANK_BP];
      word_r.highpass_right <= sat[SIDE_RIGHT*NUM_BANKS + BANK_HP];
      word_r.lowpass_right  <= sat[SIDE_RIGHT*NUM_BANKS + BANK_LP];
    end
  end

  assign word = word_r;

endmodule

`default_nettype wire

FILE: rtl/stereo_gain_fir_filter_bank.sv
// Channel   Direction  Handshake        Contents
// in_if     input      valid / ready    sample pair or coefficient write (in_word_t)
// out_if    output     valid / ready    six filtered channels and the direct left sample (out_word_t)
// cfg_*     input      APB, pready = 1  pre_gain at 0x0, output_mode at 0x4
//
// A sample word passes through the gain, tap walk, drain and done states to a loaded
// result; the single shared tap counter walks one tap per cycle for all six lanes.
// A coefficient write word is written into its bank when accepted and produces no result.
// After reset the delay lines and coefficient banks are zeroed by a sweep of the tap
// counter, during which in_if.ready stays low; configuration writes are taken throughout.
// A stalled output holds its word; the next input word is accepted meanwhile.
`default_nettype none

module stereo_gain_fir_filter_bank
  import sgfb_pkg::*;
#(
  parameter int TAPS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sgfb_chan_if.sink                  in_if,
  sgfb_chan_if.source                out_if,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int AW    = $clog2(TAPS);
  localparam int ACC_W = PROD_W + $clog2(TAPS);
  localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

  // Configuration registers.
  logic [GAIN_W-1:0] pre_gain_r;
  logic              output_mode_r;
  logic              cfg_wr;
  logic              cfg_idx;

  // Sequencer.
  state_t        state_r, state_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] pos_r;
  logic          rd_vld_r;
  logic          prod_vld_r;
  logic          out_vld_r;
  logic          first_ch_r;
  logic [SAMPLE_W-1:0] direct_left_r;

  logic       in_accept;
  logic       sample_acc;
  logic       coef_wr;
  logic       clearing;
  logic       out_load;
  lane_ctrl_t lane_ctrl;

  // Datapath.
  logic [SAMPLE_W-1:0] gained [NUM_SIDES];
  logic [SAMPLE_W-1:0] line_rd [NUM_SIDES];
  logic [SAMPLE_W-1:0] coef_rd [NUM_BANKS];
  logic [ACC_W-1:0]    acc [NUM_LANES];
  logic [AW-1:0]       line_raddr;
  logic [AW-1:0]       coef_waddr;

  // ---------------------------------------------------------------------------
  // Configuration port. Register index is the word address bit.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_gain_r    <= PRE_GAIN_RESET;
      output_mode_r <= OUTPUT_MODE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PRE_GAIN:    pre_gain_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_OUTPUT_MODE: output_mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PRE_GAIN:    cfg_prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, pre_gain_r};
      REG_OUTPUT_MODE: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, output_mode_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input decode. A coefficient word is written straight into its bank in the
  // cycle it is accepted; an unused bank or a tap beyond the filter is dropped.
  // ---------------------------------------------------------------------------
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;
  assign sample_acc  = in_accept && (in_if.payload.req_type == REQ_SAMPLE);
  assign coef_wr     = in_accept && (in_if.payload.req_type == REQ_COEF) &&
                       (int'(in_if.payload.coef_bank) < NUM_BANKS) &&
                       (int'(in_if.payload.coef_tap) < TAPS);
  assign coef_waddr  = AW'(in_if.payload.coef_tap);
  assign clearing    = (state_r == ST_CLEAR);

  // ---------------------------------------------------------------------------
  // Sequencer: clear sweep, gain, tap walk, pipeline drain, result hand-off.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      k_r        <= '0;
      pos_r      <= '0;
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      rd_vld_r   <= (state_r == ST_RUN);
      prod_vld_r <= rd_vld_r;
      if (out_load) begin
        pos_r <= (pos_r == LAST_TAP) ? '0 : pos_r + 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    out_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (k_r == LAST_TAP) begin
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (sample_acc) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        k_nxt     = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (k_r == LAST_TAP) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // Read data and products of the last tap still in flight.
        if (!rd_vld_r && !prod_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Word-side registers: the channel flag is captured with the sample, the direct left sample in the gain state.
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      first_ch_r <= ~output_mode_r;
    end
    if (state_r == ST_GAIN) begin
      direct_left_r <= gained[SIDE_LEFT];
    end
  end

  // ---------------------------------------------------------------------------
  // Pre-gain: one multiplier per side, registered, then floor shift and clamp.
  // ---------------------------------------------------------------------------
  sgfb_gain u_gain (
    .clk       (clk),
    .en        (sample_acc),
    .left_in   (in_if.payload.left_sample),
    .right_in  (in_if.payload.right_sample),
    .gain      (pre_gain_r),
    .left_out  (gained[SIDE_LEFT]),
    .right_out (gained[SIDE_RIGHT])
  );

  // ---------------------------------------------------------------------------
  // Delay lines. The newest sample goes to pos_r; tap k reads slot pos_r - k
  // modulo TAPS.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (k_r > pos_r) begin
      line_raddr = AW'({1'b0, pos_r} + (AW+1)'(TAPS) - {1'b0, k_r});
    end else begin
      line_raddr = pos_r - k_r;
    end
  end

  for (genvar s = 0; s < NUM_SIDES; s++) begin : g_line
    sgfb_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_line_ram (
      .clk   (clk),
      .we    (clearing || (state_r == ST_GAIN)),
      .waddr (clearing ? k_r : pos_r),
      .wdata (clearing ? '0 : gained[s]),
      .raddr (line_raddr),
      .rdata (line_rd[s])
    );
  end

  // Coefficient banks, all read at tap k_r.
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_coef
    sgfb_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_coef_ram (
      .clk   (clk),
      .we    (clearing || (coef_wr && (int'(in_if.payload.coef_bank) == b))),
      .waddr (clearing ? k_r : coef_waddr),
      .wdata (clearing ? '0 : in_if.payload.coef_value),
      .raddr (k_r),
      .rdata (coef_rd[b])
    );
  end

  // ---------------------------------------------------------------------------
  // Six lanes: each side against each bank. Lane control runs one stage behind
  // the RAM read and one behind the product register.
  // ---------------------------------------------------------------------------
  assign lane_ctrl.clr = (state_r == ST_GAIN);
  assign lane_ctrl.mul = rd_vld_r;
  assign lane_ctrl.acc = prod_vld_r;

  for (genvar s = 0; s < NUM_SIDES; s++) begin : g_side
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      sgfb_mac_lane #(.ACC_W(ACC_W)) u_lane (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .coef   (coef_rd[b]),
        .sample (line_rd[s]),
        .acc    (acc[s*NUM_BANKS + b])
      );
    end
  end

  // Merge: scale and clamp all six accumulators into the output word.
  sgfb_merge #(.ACC_W(ACC_W)) u_merge (
    .clk           (clk),
    .load          (out_load),
    .first_channel (first_ch_r),
    .direct_left   (direct_left_r),
    .acc           (acc),
    .word          (out_if.payload)
  );

  assign out_if.valid = out_vld_r;

`ifndef NO_ASSERTIONS
  // After acceptance, a sample word passes through the gain state into the tap walk.
  a_sample_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> ##1 (state_r == ST_RUN))
    else $error("sample word did not start the tap walk");

  // Products are only in flight during the tap walk and its drain.
  a_prod_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    prod_vld_r |-> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("product valid outside the tap walk");

  // The lane pipeline is empty whenever a result is ready to load.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!rd_vld_r && !prod_vld_r))
    else $error("result loaded before the lanes drained");

  // The write position only moves when a result is handed off.
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(pos_r))
    else $error("write position moved without a result");
`endif

endmodule

`default_nettype wire
